FILE: design/hpack_header_field_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// HPACK header field encoder assertion macros
// Concurrent assertion helpers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef HPACK_HEADER_FIELD_ENCODER_CORE_ASSERT_SVH
`define HPACK_HEADER_FIELD_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define HFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HFE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/hfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK header field encoder package
// Mode codes, byte constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package hfe_pkg;

    localparam int NUMBER_W = 32;

    localparam logic [2:0] MODE_INDEXED   = 3'd0;
    localparam logic [2:0] MODE_LIT_IDX   = 3'd1;
    localparam logic [2:0] MODE_LIT_NOIDX = 3'd2;
    localparam logic [2:0] MODE_STR_LEN   = 3'd3;
    localparam logic [2:0] MODE_IDX_NAME  = 3'd4;
    localparam logic [2:0] MODE_SIZE_CHG  = 3'd5;
    localparam logic [2:0] MODE_RAW       = 3'd6;
    localparam logic [2:0] MODE_UNUSED    = 3'd7;

    localparam logic [7:0] FLAG_INDEXED  = 8'h80;
    localparam logic [7:0] FLAG_SIZECHG  = 8'h20;
    localparam logic [7:0] TYPE_INDEXING = 8'h40;
    localparam logic [7:0] TYPE_PLAIN    = 8'h00;
    localparam logic [7:0] FLAG_CONT     = 8'h80;
    localparam logic [7:0] LIMIT_7       = 8'h7f;
    localparam logic [7:0] LIMIT_4       = 8'h0f;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TYPE,
        ST_FIRST,
        ST_GROUP,
        ST_RAW
    } t_state;

    typedef enum logic [1:0] {
        SEL_TYPE,
        SEL_FIRST,
        SEL_GROUP,
        SEL_RAW
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_emit_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic first_small;
        logic group_last;
    } t_dp_status;

endpackage

FILE: design/hfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK header field encoder controller
// Sequences the type byte, prefix byte and continuation groups of a request, or its single raw byte.
// ----------------------------------------------------------------------------
module hfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_mode,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  hfe_pkg::t_dp_status i_status,
    output hfe_pkg::t_dp_cmd  o_cmd
);
    import hfe_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_free;

    assign w_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_mode)
                        MODE_LIT_IDX, MODE_LIT_NOIDX: n_state = ST_TYPE;
                        MODE_INDEXED, MODE_STR_LEN,
                        MODE_IDX_NAME, MODE_SIZE_CHG: n_state = ST_FIRST;
                        MODE_RAW: n_state = ST_RAW;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TYPE: begin
                if (w_free) n_state = ST_FIRST;
            end
            ST_FIRST: begin
                if (w_free) n_state = i_status.first_small ? ST_IDLE : ST_GROUP;
            end
            ST_GROUP: begin
                if (w_free && i_status.group_last) n_state = ST_IDLE;
            end
            ST_RAW: begin
                if (w_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall    = (r_state != ST_IDLE);
        o_cmd.load = (r_state == ST_IDLE) && i_valid;
        o_cmd.emit = (r_state != ST_IDLE) && w_free;
        unique case (r_state)
            ST_TYPE:  o_cmd.sel = SEL_TYPE;
            ST_GROUP: o_cmd.sel = SEL_GROUP;
            ST_RAW:   o_cmd.sel = SEL_RAW;
            default:  o_cmd.sel = SEL_FIRST;
        endcase
        n_out_valid = o_cmd.emit || (r_out_valid && i_stall);
    end

    assign o_valid = r_out_valid;

endmodule

FILE: design/hfe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK header field encoder datapath
// Holds the request fields, forms output bytes and steps the integer value.
// ----------------------------------------------------------------------------
module hfe_dp (
    input  logic                         i_clk,
    input  logic [2:0]                   i_mode,
    input  logic [hfe_pkg::NUMBER_W-1:0] i_number,
    input  logic [7:0]                   i_data_byte,
    input  hfe_pkg::t_dp_cmd             i_cmd,
    output hfe_pkg::t_dp_status          o_status,
    output logic [7:0]                   o_out_byte,
    output logic                         o_last
);
    import hfe_pkg::*;

    logic [2:0]          r_mode;
    logic [NUMBER_W-1:0] r_value;
    logic [7:0]          r_data;
    logic [7:0]          r_out_byte;
    logic                r_out_last;
    logic [NUMBER_W-1:0] n_value;
    logic [7:0]          n_out_byte;
    logic                n_out_last;
    logic [7:0]          w_limit;
    logic [7:0]          w_flag;
    logic                w_small;
    logic                w_glast;

    always_comb begin
        w_limit = ((r_mode == MODE_IDX_NAME) || (r_mode == MODE_SIZE_CHG)) ? LIMIT_4 : LIMIT_7;
        unique if (r_mode == MODE_INDEXED) begin
            w_flag = FLAG_INDEXED;
        end else if (r_mode == MODE_SIZE_CHG) begin
            w_flag = FLAG_SIZECHG;
        end else begin
            w_flag = 8'h00;
        end
        w_small = (r_value < {{(NUMBER_W-8){1'b0}}, w_limit});
        w_glast = (r_value[NUMBER_W-1:7] == '0);
    end

    always_comb begin
        n_value    = r_value;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        if (i_cmd.emit) begin
            unique case (i_cmd.sel)
                SEL_TYPE: begin
                    n_out_byte = (r_mode == MODE_LIT_IDX) ? TYPE_INDEXING : TYPE_PLAIN;
                    n_out_last = 1'b0;
                end
                SEL_FIRST: begin
                    n_out_last = w_small;
                    if (w_small) begin
                        n_out_byte = r_value[7:0] | w_flag;
                    end else begin
                        n_out_byte = w_limit | w_flag;
                        n_value    = r_value - {{(NUMBER_W-8){1'b0}}, w_limit};
                    end
                end
                SEL_GROUP: begin
                    n_out_byte = {~w_glast, r_value[6:0]};
                    n_out_last = w_glast;
                    n_value    = {7'd0, r_value[NUMBER_W-1:7]};
                end
                SEL_RAW: begin
                    n_out_byte = r_data;
                    n_out_last = 1'b1;
                end
                default: begin
                    n_out_byte = r_out_byte;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_number;
            r_data  <= i_data_byte;
        end else begin
            r_value <= n_value;
        end
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_status   = '{first_small: w_small, group_last: w_glast};
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

FILE: design/hpack_header_field_encoder_core.sv
`timescale 1ns / 1ps
// A request is registered into the datapath, and its bytes then pass one at a
// time through the single output register. The controller emits one byte per
// cycle while the output is not stalled, and holds o_stall high, taking no new
// request, until the last byte of the current request has been emitted.
// Reset: synchronous, active low; clears the controller state and output valid.
// ----------------------------------------------------------------------------
// HPACK header field encoder core
// Encodes prefix integers and passes string bytes as a byte stream.
// ----------------------------------------------------------------------------
module hpack_header_field_encoder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_mode,
    input  logic [hfe_pkg::NUMBER_W-1:0] i_number,
    input  logic [7:0]                   i_data_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_out_byte,
    output logic                         o_last
);
    import hfe_pkg::*;

`include "hpack_header_field_encoder_core_assert.svh"

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    hfe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    hfe_dp u_dp (
        .i_clk       (i_clk),
        .i_mode      (i_mode),
        .i_number    (i_number),
        .i_data_byte (i_data_byte),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    `HFE_ASSERT_SAME(a_idle_pending_last, i_clk, i_rst_n, !o_stall && o_valid, o_last)
    `HFE_ASSERT_NEXT(a_raw_busy, i_clk, i_rst_n, i_valid && !o_stall && i_mode == MODE_RAW, o_stall)
    `HFE_ASSERT_NEXT(a_unused_idle, i_clk, i_rst_n, i_valid && !o_stall && i_mode == MODE_UNUSED, !o_stall)

endmodule
